>>> src/mje_pkg.sv
package mje_pkg;

  localparam int JUMP_W        = 8;
  localparam int OUT_W         = 16;
  localparam int MAX_JUMP_DEF  = 255;
  localparam int CNT_WIDTH_DEF = 16;

  // broadcast from the top level to every cell of the window
  typedef struct packed {
    logic              shift;
    logic              relax;
    logic              clear;
    logic [JUMP_W-1:0] jump_len;
  } cell_ctl_t;

endpackage

>>> src/mje_req_if.sv
interface mje_req_if;
  logic                       valid;
  logic                       ready;
  logic [mje_pkg::JUMP_W-1:0] jump_len;
  logic                       last;

  modport source (output valid, output jump_len, output last, input ready);
  modport sink (input valid, input jump_len, input last, output ready);
endinterface

>>> src/mje_rsp_if.sv
interface mje_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [mje_pkg::OUT_W-1:0] jump_cnt;
  logic                      reachable;

  modport source (output valid, output jump_cnt, output reachable, input ready);
  modport sink (input valid, input jump_cnt, input reachable, output ready);
endinterface

>>> src/mje_cell.sv
module mje_cell #(
  parameter int CellIdx    = 0,
  parameter int CountWidth = mje_pkg::CNT_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mje_pkg::cell_ctl_t    ctl_i,
  input  logic [CountWidth-1:0] nc_i,
  input  logic [CountWidth-1:0] next_cnt_i,
  input  logic                  next_unr_i,
  output logic [CountWidth-1:0] cnt_o,
  output logic                  unr_o
);

  logic [CountWidth-1:0] cnt_q;
  logic                  unr_q;
  logic                  in_reach;
  logic                  hit;

  // this position lies within the jump of the current one
  assign in_reach = int'(ctl_i.jump_len) > CellIdx;
  assign hit      = ctl_i.relax && in_reach && (unr_q || (nc_i < cnt_q));

  // relaxed value, handed to the left neighbor
  assign cnt_o = hit ? nc_i : cnt_q;
  assign unr_o = hit ? 1'b0 : unr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unr_q <= 1'b1;
    end else if (ctl_i.clear) begin
      unr_q <= 1'b1;
    end else if (ctl_i.shift) begin
      unr_q <= next_unr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      cnt_q <= next_cnt_i;
    end
  end

endmodule

>>> src/min_jumps_to_end.sv
// minimum jumps to reach the end of a sequence
//
// req_i carries one position per request: jump_len is the longest jump
// allowed from it, last marks the final position. rsp_o gives one result
// per sequence, after the request with last set: jump_cnt (saturating at
// 65535) and reachable. an unreachable end gives jump_cnt 0.
// a one-position sequence answers 0, reachable.
//
// a request is taken every cycle: the window of MaxJump cells relaxes all
// reachable positions at once and shifts by one in the same edge. the
// result is registered, so it shows in the cycle after the last request.
// while a result waits and rsp_o.ready is low, req_i.ready is low too;
// with rsp_o.ready high the block keeps one request per cycle.
//
// reset (asynchronous, rst_ni low) marks every window cell unreachable and
// the start position reachable with count 0; the same happens after each
// last request, so sequences follow back to back.
module min_jumps_to_end #(
  parameter int MaxJump    = mje_pkg::MAX_JUMP_DEF,
  parameter int CountWidth = mje_pkg::CNT_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mje_req_if.sink    req_i,
  mje_rsp_if.source  rsp_o
);

  localparam int OutW = mje_pkg::OUT_W;
  localparam int ExtW = (CountWidth > OutW) ? CountWidth : OutW;
  localparam logic [CountWidth-1:0] CntMax = {CountWidth{1'b1}};
  localparam logic [ExtW-1:0] OutMaxExt = ExtW'({OutW{1'b1}});

  logic [CountWidth-1:0] cur_cnt_q;
  logic                  cur_unr_q;
  logic                  out_valid_q;
  logic [OutW-1:0]       out_cnt_q;
  logic                  out_reach_q;

  logic                  accept;
  logic [CountWidth-1:0] nc;
  logic [ExtW-1:0]       cur_ext;
  logic [OutW-1:0]       cur_sat;
  mje_pkg::cell_ctl_t    ctl;

  logic [CountWidth-1:0] chain_cnt [MaxJump+1];
  logic                  chain_unr [MaxJump+1];

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign nc = (cur_cnt_q == CntMax) ? CntMax : cur_cnt_q + CountWidth'(1);

  assign ctl.shift    = accept && !req_i.last;
  assign ctl.relax    = accept && !req_i.last && !cur_unr_q;
  assign ctl.clear    = accept && req_i.last;
  assign ctl.jump_len = req_i.jump_len;

  // beyond the window everything is unreachable
  assign chain_cnt[MaxJump] = '0;
  assign chain_unr[MaxJump] = 1'b1;

  for (genvar k = 0; k < MaxJump; k++) begin : g_cell
    mje_cell #(
      .CellIdx    (k),
      .CountWidth (CountWidth)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .nc_i       (nc),
      .next_cnt_i (chain_cnt[k+1]),
      .next_unr_i (chain_unr[k+1]),
      .cnt_o      (chain_cnt[k]),
      .unr_o      (chain_unr[k])
    );
  end

  assign cur_ext = ExtW'(cur_cnt_q);
  assign cur_sat = (cur_ext > OutMaxExt) ? {OutW{1'b1}} : cur_ext[OutW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_cnt_q <= '0;
      cur_unr_q <= 1'b0;
    end else if (ctl.clear) begin
      cur_cnt_q <= '0;
      cur_unr_q <= 1'b0;
    end else if (ctl.shift) begin
      cur_cnt_q <= chain_cnt[0];
      cur_unr_q <= chain_unr[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.clear) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.clear) begin
      out_cnt_q   <= cur_unr_q ? '0 : cur_sat;
      out_reach_q <= !cur_unr_q;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.jump_cnt  = out_cnt_q;
  assign rsp_o.reachable = out_reach_q;

  // a new result only follows a last request
  a_rsp_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(accept && req_i.last))
    else $error("result without a last request");

  // a fresh sequence starts reachable at count zero
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.last) |=> (cur_cnt_q == '0 && !cur_unr_q))
    else $error("start position not restored");

  // unreachable end reports zero jumps
  a_unreach_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_reach_q) |-> (out_cnt_q == '0))
    else $error("unreachable result with nonzero count");

  // a reachable position with a nonzero jump makes the next one reachable
  a_reach_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.relax && req_i.jump_len != '0) |=> !cur_unr_q)
    else $error("next position lost reachability");

endmodule
